FILE: rtl/l4hsc_pkg.sv
package l4hsc_pkg;

	localparam int SESSIONS = 256;
	localparam int TABLE_DEPTH = 2 * SESSIONS;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam logic [7:0] FILL_HASH = 8'hb7;
	localparam logic [15:0] LEN_BIAS = 16'd22;
	localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;
	localparam logic [2:0] LAST_WORD = 3'd4;
	localparam logic CMD_CLASSIFY = 1'b0;
	localparam logic CMD_DECOMP = 1'b1;
	localparam logic KIND_CLASSIFY = 1'b0;
	localparam logic KIND_HEADER = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic        direction;
		logic [7:0]  session_in;
		logic [15:0] compressed_len;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] ethertype;
		logic [15:0] ver_len_tos;
		logic [31:0] ip_fixed;
		logic [63:0] ip_addrs;
		logic [31:0] ports;
		logic [15:0] ip_id;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  session_out;
		logic        hit;
		logic        collision;
		logic [31:0] packet_count;
		logic [63:0] header_word;
		logic [3:0]  word_bytes;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] count;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [31:0] type_tos;
		logic [31:0] ip_fixed;
		logic [63:0] addrs;
		logic [31:0] ports;
	} entry_t;

	typedef struct packed {
		logic              capture;
		logic              clr_en;
		logic [ADDR_W-1:0] clr_addr;
		logic              eval_cls;
		logic              ck1;
		logic              ck2;
		logic              emit;
		logic [2:0]        word_idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic cmd;
		logic out_free;
		logic out_done;
	} ctl_status_t;

	// xor of the 32 variable session bytes, seeded with FILL_HASH
	function automatic logic [7:0] session_hash(input logic [255:0] v);
		logic [7:0] h;
		h = FILL_HASH;
		for (int k = 0; k < 32; k++) begin
			h = h ^ v[8*k +: 8];
		end
		return h;
	endfunction

endpackage

FILE: rtl/l4_header_session_compressor_top.sv
// Ethernet/IPv4/L4 header session compressor. After reset the session table
// (two directions of 256 entries) is cleared one entry per cycle with in_ready
// low. One transaction is handled at a time: a classify reads its entry (RD),
// then registers its result and writes the entry back (EVAL); a decompress
// reads its entry, runs the two-step checksum adder (CK1, CK2) and then presents
// its header words one word per cycle while the output is not stalled. The next
// transaction is taken only after the last result or header word has been taken
// by the output.
module l4_header_session_compressor_top
	import l4hsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	ctl_cmd_t    cmd;
	ctl_status_t status;

	l4hsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	l4hsc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

FILE: rtl/l4hsc_ctrl.sv
module l4hsc_ctrl
	import l4hsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ctl_status_t status,
	output ctl_cmd_t    cmd
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_CK1   = 3'd4;
	localparam logic [2:0] ST_CK2   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;
	localparam logic [2:0] ST_DRAIN = 3'd7;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [2:0]        word_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.capture = in_valid && in_ready;
		cmd.clr_en = (state_q == ST_CLR);
		cmd.clr_addr = clr_q;
		cmd.eval_cls = (state_q == ST_EVAL) && (status.cmd == CMD_CLASSIFY);
		cmd.ck1 = (state_q == ST_CK1);
		cmd.ck2 = (state_q == ST_CK2);
		cmd.emit = (state_q == ST_EMIT) && status.out_free;
		cmd.word_idx = word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			word_q <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_EVAL;
				ST_EVAL: begin
					state_q <= (status.cmd == CMD_CLASSIFY) ? ST_DRAIN : ST_CK1;
				end
				ST_CK1: state_q <= ST_CK2;
				ST_CK2: begin
					word_q <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free) begin
						word_q <= word_q + 1'b1;
						if (word_q == LAST_WORD) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (status.out_done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !in_ready)
		else $error("input taken during table clear");
	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> word_q <= LAST_WORD)
		else $error("header word index out of range");
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_RD)
		else $error("accepted transaction did not start a table read");
	a_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.eval_cls && cmd.emit) && !(cmd.clr_en && cmd.eval_cls))
		else $error("conflicting datapath commands");

endmodule

FILE: rtl/l4hsc_datapath.sv
module l4hsc_datapath
	import l4hsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_data,
	input  ctl_cmd_t    cmd,
	output ctl_status_t status,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	entry_t            mem [TABLE_DEPTH];
	entry_t            rdata_q;
	in_item_t          item_q;
	logic [7:0]        hash_q;
	logic [ADDR_W-1:0] idx_q;
	logic [18:0]       sum_q;
	logic [15:0]       csum_q;
	logic              out_valid_q;
	out_item_t         out_q;

	entry_t      new_ent;
	entry_t      wr_ent;
	logic        hit;
	logic        we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0] len;
	logic [19:0] sum2;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [63:0] word;
	logic [31:0] next_count;
	out_item_t   out_nxt;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
			hash_q <= session_hash({in_data.dst_mac, in_data.src_mac, in_data.ethertype,
				in_data.ver_len_tos, in_data.ip_fixed, in_data.ip_addrs, in_data.ports});
		end
	end

	// table index follows the command: hash for classify, given session for decompress
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= {in_data.direction, (in_data.cmd == CMD_CLASSIFY) ?
				session_hash({in_data.dst_mac, in_data.src_mac, in_data.ethertype,
				in_data.ver_len_tos, in_data.ip_fixed, in_data.ip_addrs, in_data.ports}) :
				in_data.session_in};
		end
	end

	always_comb begin
		new_ent.valid = 1'b1;
		new_ent.count = 32'd1;
		new_ent.dst_mac = item_q.dst_mac;
		new_ent.src_mac = item_q.src_mac;
		new_ent.type_tos = {item_q.ethertype, item_q.ver_len_tos};
		new_ent.ip_fixed = item_q.ip_fixed;
		new_ent.addrs = item_q.ip_addrs;
		new_ent.ports = item_q.ports;
		hit = rdata_q.valid && (rdata_q.dst_mac == new_ent.dst_mac)
			&& (rdata_q.src_mac == new_ent.src_mac) && (rdata_q.type_tos == new_ent.type_tos)
			&& (rdata_q.ip_fixed == new_ent.ip_fixed) && (rdata_q.addrs == new_ent.addrs)
			&& (rdata_q.ports == new_ent.ports);
		next_count = (rdata_q.count == COUNT_MAX) ? COUNT_MAX : rdata_q.count + 32'd1;
		if (cmd.clr_en) begin
			wr_ent = '0;
		end else if (hit) begin
			wr_ent = rdata_q;
			wr_ent.count = next_count;
		end else begin
			wr_ent = new_ent;
		end
		we = cmd.clr_en || cmd.eval_cls;
		waddr = cmd.clr_en ? cmd.clr_addr : idx_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wr_ent;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[idx_q];
	end

	// checksum: entry words first, then length and id, then end-around fold
	assign len = item_q.compressed_len + LEN_BIAS;
	assign sum2 = {1'b0, sum_q} + {4'd0, len} + {4'd0, item_q.ip_id};
	assign fold1 = {1'b0, sum2[15:0]} + {13'd0, sum2[19:16]};
	assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

	always_ff @(posedge clk) begin
		if (cmd.ck1) begin
			sum_q <= {3'd0, rdata_q.type_tos[15:0]} + {3'd0, rdata_q.ip_fixed[31:16]}
				+ {3'd0, rdata_q.ip_fixed[15:0]} + {3'd0, rdata_q.addrs[63:48]}
				+ {3'd0, rdata_q.addrs[47:32]} + {3'd0, rdata_q.addrs[31:16]}
				+ {3'd0, rdata_q.addrs[15:0]};
		end
		if (cmd.ck2) csum_q <= ~fold2;
	end

	always_comb begin
		case (cmd.word_idx)
			3'd0: word = {rdata_q.dst_mac, rdata_q.src_mac[47:32]};
			3'd1: word = {rdata_q.src_mac[31:0], rdata_q.type_tos};
			3'd2: word = {len, item_q.ip_id, rdata_q.ip_fixed};
			3'd3: word = {csum_q, rdata_q.addrs[63:16]};
			default: word = {rdata_q.addrs[15:0], rdata_q.ports, 16'd0};
		endcase
	end

	always_comb begin
		out_nxt = '0;
		if (cmd.eval_cls) begin
			out_nxt.result_kind = KIND_CLASSIFY;
			out_nxt.session_out = hash_q;
			out_nxt.hit = hit;
			out_nxt.collision = rdata_q.valid && !hit;
			out_nxt.packet_count = hit ? next_count : 32'd1;
			out_nxt.last = 1'b1;
		end else begin
			out_nxt.result_kind = KIND_HEADER;
			out_nxt.header_word = word;
			out_nxt.word_bytes = (cmd.word_idx == LAST_WORD) ? 4'd6 : 4'd8;
			out_nxt.last = (cmd.word_idx == LAST_WORD);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.eval_cls || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_cls || cmd.emit) out_q <= out_nxt;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign status.cmd = item_q.cmd;
	assign status.out_free = !out_valid_q || out_ready;
	assign status.out_done = out_valid_q && out_ready && out_q.last;

endmodule
